@@ hw/rtl/rcpw_pkg.sv @@
// ----------------------------------------------------------------------------
// rcpw_pkg: shared types and constants of the RC pulse-width capture block
// Register indexes, config and channel-store structs, divider sizes and
// the per-channel reset widths.
// ----------------------------------------------------------------------------
package rcpw_pkg;

  // Microsecond width of the pulse-width fields
  localparam int unsigned UsW   = 12;
  localparam int unsigned TimeW = 32;

  // Serial divider: 27-bit dividend, 12-bit divisor, 15 quotient bits
  localparam int unsigned DivNW = 27;
  localparam int unsigned DivQW = 15;

  // Fixed-point scales
  localparam logic [14:0] PctFull = 15'd25600;
  localparam int unsigned UnitFracW = 14;

  // Operation codes
  localparam logic [1:0] OP_EDGE  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_VALID_MIN  = 3'd0;
  localparam logic [2:0] CFG_VALID_MAX  = 3'd1;
  localparam logic [2:0] CFG_CLAMP_MIN  = 3'd2;
  localparam logic [2:0] CFG_CLAMP_MAX  = 3'd3;
  localparam logic [2:0] CFG_CENTER     = 3'd4;
  localparam logic [2:0] CFG_HALF_RANGE = 3'd5;
  localparam logic [2:0] CFG_TIMEOUT    = 3'd6;

  // Reset width of each channel slot
  localparam logic [7:0][UsW-1:0] WidthReset = {
    12'd1500, 12'd1500, 12'd1000, 12'd1000,
    12'd1500, 12'd1000, 12'd1500, 12'd1500
  };

  typedef struct packed {
    logic [UsW-1:0]   valid_min;
    logic [UsW-1:0]   valid_max;
    logic [UsW-1:0]   clamp_min;
    logic [UsW-1:0]   clamp_max;
    logic [UsW-1:0]   center;
    logic [UsW-1:0]   half_range;
    logic [TimeW-1:0] timeout;
  } cfg_t;

  // Write request to the channel store
  typedef struct packed {
    logic             set_rise;
    logic             set_width;
    logic             set_new;
    logic             new_val;
    logic             set_last;
    logic [TimeW-1:0] stamp;
    logic [UsW-1:0]   width;
  } st_wr_t;

  // Read data from the channel store
  typedef struct packed {
    logic [TimeW-1:0] rise;
    logic [UsW-1:0]   width;
    logic             new_flag;
    logic [TimeW-1:0] last;
    logic [TimeW-1:0] thr_last;
  } st_rd_t;

endpackage

@@ hw/rtl/rcpw_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// rcpw_cfg_regs: configuration register file
// Seven registers written through a valid/ready channel; always ready.
// ----------------------------------------------------------------------------
module rcpw_cfg_regs
  import rcpw_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.valid_min  <= 12'd800;
      cfg_q.valid_max  <= 12'd2500;
      cfg_q.clamp_min  <= 12'd1000;
      cfg_q.clamp_max  <= 12'd2000;
      cfg_q.center     <= 12'd1500;
      cfg_q.half_range <= 12'd500;
      cfg_q.timeout    <= 32'd100000;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_VALID_MIN:  cfg_q.valid_min  <= cfg_data_i[UsW-1:0];
        CFG_VALID_MAX:  cfg_q.valid_max  <= cfg_data_i[UsW-1:0];
        CFG_CLAMP_MIN:  cfg_q.clamp_min  <= cfg_data_i[UsW-1:0];
        CFG_CLAMP_MAX:  cfg_q.clamp_max  <= cfg_data_i[UsW-1:0];
        CFG_CENTER:     cfg_q.center     <= cfg_data_i[UsW-1:0];
        CFG_HALF_RANGE: cfg_q.half_range <= cfg_data_i[UsW-1:0];
        CFG_TIMEOUT:    cfg_q.timeout    <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/rcpw_chan_store.sv @@
// ----------------------------------------------------------------------------
// rcpw_chan_store: per-channel capture state
// Rise time, stored width, new-data flag and last-update time per channel,
// one write port and one read port, plus a fixed tap on the throttle channel.
// ----------------------------------------------------------------------------
module rcpw_chan_store
  import rcpw_pkg::*;
#(
  parameter int unsigned CHANNELS         = 6,
  parameter int unsigned THROTTLE_CHANNEL = 2,
  parameter int unsigned IdxW             = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_idx_i,
  input  st_wr_t          wr_i,
  input  logic [IdxW-1:0] rd_idx_i,
  output st_rd_t          rd_o
);

  logic [TimeW-1:0] rise_q [CHANNELS];
  logic [UsW-1:0]   width_q [CHANNELS];
  logic             new_q [CHANNELS];
  logic [TimeW-1:0] last_q [CHANNELS];

  // State update, one channel per write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        rise_q[i]  <= '0;
        width_q[i] <= WidthReset[i];
        new_q[i]   <= 1'b0;
        last_q[i]  <= '0;
      end
    end else if (wr_en_i) begin
      if (wr_i.set_rise)  rise_q[wr_idx_i]  <= wr_i.stamp;
      if (wr_i.set_width) width_q[wr_idx_i] <= wr_i.width;
      if (wr_i.set_new)   new_q[wr_idx_i]   <= wr_i.new_val;
      if (wr_i.set_last)  last_q[wr_idx_i]  <= wr_i.stamp;
    end
  end

  assign rd_o.rise     = rise_q[rd_idx_i];
  assign rd_o.width    = width_q[rd_idx_i];
  assign rd_o.new_flag = new_q[rd_idx_i];
  assign rd_o.last     = last_q[rd_idx_i];

  // Throttle tap; a zero stamp reads as never updated
  generate
    if (THROTTLE_CHANNEL < CHANNELS) begin : g_thr
      localparam logic [IdxW-1:0] ThrIdx = IdxW'(THROTTLE_CHANNEL);
      assign rd_o.thr_last = last_q[ThrIdx];
    end else begin : g_no_thr
      assign rd_o.thr_last = '0;
    end
  endgenerate

endmodule

@@ hw/rtl/rcpw_divider.sv @@
// ----------------------------------------------------------------------------
// rcpw_divider: shared restoring divider
// One quotient bit per cycle; the quotient must fit in DivQW bits, so the
// top dividend bits start as the partial remainder.
// ----------------------------------------------------------------------------
module rcpw_divider
  import rcpw_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivNW-1:0] num_i,
  input  logic [UsW-1:0]   den_i,
  output logic             done_o,
  output logic [DivQW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(DivQW);
  localparam logic [CntW-1:0] LastStep = CntW'(DivQW - 1);

  logic             run_q;
  logic             done_q;
  logic [CntW-1:0]  cnt_q;
  logic [UsW-1:0]   rem_q, rem_d;
  logic [DivQW-1:0] low_q, low_d;
  logic [UsW-1:0]   den_q;
  logic [UsW:0]     trial;
  logic             ge;

  // One subtract-and-compare step
  always_comb begin
    trial = {rem_q, low_q[DivQW-1]};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? UsW'(trial - {1'b0, den_q}) : trial[UsW-1:0];
    low_d = {low_q[DivQW-2:0], ge};
  end

  // Sequencing of the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastStep) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[DivNW-1:DivQW];
      low_q <= num_i[DivQW-1:0];
      den_q <= den_i;
    end else if (run_q) begin
      rem_q <= rem_d;
      low_q <= low_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = low_q;

endmodule

@@ hw/rtl/rc_pulse_width_capture.sv @@
// ----------------------------------------------------------------------------
// rc_pulse_width_capture: multi-channel RC pulse-width capture
// Edge, read and clear items; one result per item with raw, clamped,
// percent and unit positions, new-data flag and freshness.
// ----------------------------------------------------------------------------
// An invalid channel goes from the update state straight to the result; a valid
// one steps through clamp, percent and unit first. A new item is taken only after
// the done strobe of the last one. The shared 15-step divider serves percent then unit.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset: registers to their defaults, widths to the per-channel reset table.
module rc_pulse_width_capture
  import rcpw_pkg::*;
#(
  parameter int unsigned CHANNELS         = 6,
  parameter int unsigned THROTTLE_CHANNEL = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  // items
  input  logic               start_i,
  output logic               busy_o,
  input  logic [1:0]         operation_i,
  input  logic [2:0]         channel_i,
  input  logic               level_i,
  input  logic [31:0]        time_us_i,
  // results
  output logic               done_o,
  output logic               channel_valid_o,
  output logic               width_accepted_o,
  output logic [11:0]        raw_us_o,
  output logic [11:0]        clamped_us_o,
  output logic [14:0]        percent_q8_o,
  output logic signed [15:0] unit_q14_o,
  output logic               new_data_o,
  output logic               fresh_o,
  output logic               receiver_active_o,
  output logic [31:0]        last_update_us_o
);

  localparam int unsigned IdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UPD    = 3'd1;
  localparam logic [2:0] S_CLAMP  = 3'd2;
  localparam logic [2:0] S_PCT    = 3'd3;
  localparam logic [2:0] S_PCT_W  = 3'd4;
  localparam logic [2:0] S_UNIT   = 3'd5;
  localparam logic [2:0] S_UNIT_W = 3'd6;
  localparam logic [2:0] S_OUT    = 3'd7;

  localparam logic signed [15:0] UnitOne = 16'sd16384;

  logic [2:0] state_q, state_d;

  cfg_t   cfg;
  st_wr_t st_wr;
  st_rd_t st_rd;
  logic   st_wr_en;

  // latched item
  logic [1:0]       op_q;
  logic [2:0]       ch_q;
  logic             level_q;
  logic [TimeW-1:0] now_q;
  logic [IdxW-1:0]  idx;
  logic             ch_ok;

  // result registers
  logic                chan_valid_q, accepted_q, new_q, fresh_q, active_q;
  logic [UsW-1:0]      raw_q, clamped_q;
  logic [14:0]         percent_q;
  logic signed [15:0]  unit_q;
  logic [TimeW-1:0]    last_q;
  logic                neg_q;

  // shared divider
  logic             div_start;
  logic [DivNW-1:0] div_num;
  logic [UsW-1:0]   div_den;
  logic             div_done;
  logic [DivQW-1:0] div_quot;

  // combinational helpers
  logic [TimeW-1:0] width_w;
  logic             width_ok;
  logic [UsW-1:0]   clamp_lo, clamp_v;
  logic [UsW-1:0]   pct_span, pct_off;
  logic signed [UsW:0] diff;
  logic [UsW-1:0]   diff_abs;

  // one spare bit so that a full set of eight channels still compares
  assign ch_ok = {1'b0, channel_i} < 4'(CHANNELS);
  assign idx   = ch_q[IdxW-1:0];

  rcpw_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rcpw_chan_store #(
    .CHANNELS         (CHANNELS),
    .THROTTLE_CHANNEL (THROTTLE_CHANNEL),
    .IdxW             (IdxW)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (st_wr_en),
    .wr_idx_i (idx),
    .wr_i     (st_wr),
    .rd_idx_i (idx),
    .rd_o     (st_rd)
  );

  rcpw_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Store writes for edge and clear items: wrapped width and window check
  always_comb begin
    width_w  = now_q - st_rd.rise;
    width_ok = (width_w >= {20'd0, cfg.valid_min}) && (width_w <= {20'd0, cfg.valid_max});
    st_wr_en = (state_q == S_UPD) && chan_valid_q;
    st_wr           = '0;
    st_wr.stamp     = now_q;
    st_wr.width     = width_w[UsW-1:0];
    case (op_q)
      OP_EDGE: begin
        st_wr.set_rise  = level_q;
        st_wr.set_width = !level_q && width_ok;
        st_wr.set_new   = !level_q && width_ok;
        st_wr.new_val   = 1'b1;
        st_wr.set_last  = !level_q && width_ok;
      end
      OP_CLEAR: begin
        st_wr.set_new = 1'b1;
        st_wr.new_val = 1'b0;
      end
      default: ;
    endcase
  end

  // Clamp and the operands for both divisions
  always_comb begin
    clamp_lo = (st_rd.width < cfg.clamp_min) ? cfg.clamp_min : st_rd.width;
    clamp_v  = (clamp_lo > cfg.clamp_max) ? cfg.clamp_max : clamp_lo;
    pct_span = cfg.clamp_max - cfg.clamp_min;
    pct_off  = clamped_q - cfg.clamp_min;
    diff     = $signed({1'b0, raw_q}) - $signed({1'b0, cfg.center});
    diff_abs = diff[UsW] ? UsW'(-diff) : diff[UsW-1:0];
    div_start = 1'b0;
    div_num   = DivNW'(pct_off) * DivNW'(PctFull);
    div_den   = pct_span;
    if (state_q == S_PCT) begin
      div_start = cfg.clamp_max > cfg.clamp_min;
    end else if (state_q == S_UNIT) begin
      div_num   = DivNW'({diff_abs, {UnitFracW{1'b0}}});
      div_den   = cfg.half_range;
      div_start = (cfg.half_range != '0) && (diff_abs < cfg.half_range);
    end
  end

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (start_i) state_d = S_UPD;
      S_UPD:    state_d = chan_valid_q ? S_CLAMP : S_OUT;
      S_CLAMP:  state_d = S_PCT;
      S_PCT:    state_d = div_start ? S_PCT_W : S_UNIT;
      S_PCT_W:  if (div_done) state_d = S_UNIT;
      S_UNIT:   state_d = div_start ? S_UNIT_W : S_OUT;
      S_UNIT_W: if (div_done) state_d = S_OUT;
      S_OUT:    state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Item latch and result registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        op_q         <= operation_i;
        ch_q         <= channel_i;
        level_q      <= level_i;
        now_q        <= time_us_i;
        chan_valid_q <= ch_ok;
      end
      S_UPD: begin
        accepted_q <= chan_valid_q && (op_q == OP_EDGE) && !level_q && width_ok;
        raw_q      <= '0;
        clamped_q  <= '0;
        percent_q  <= '0;
        unit_q     <= '0;
        new_q      <= 1'b0;
        fresh_q    <= 1'b0;
        active_q   <= 1'b0;
        last_q     <= '0;
      end
      S_CLAMP: begin
        raw_q     <= st_rd.width;
        clamped_q <= clamp_v;
        new_q     <= st_rd.new_flag;
        last_q    <= st_rd.last;
        fresh_q   <= (st_rd.last != '0) && ((now_q - st_rd.last) <= cfg.timeout);
        active_q  <= (st_rd.thr_last != '0) && ((now_q - st_rd.thr_last) <= cfg.timeout);
      end
      S_PCT: begin
        // equal bounds give zero, inverted bounds full scale
        if (cfg.clamp_max == cfg.clamp_min) begin
          percent_q <= '0;
        end else if (cfg.clamp_max < cfg.clamp_min) begin
          percent_q <= PctFull;
        end
      end
      S_PCT_W: if (div_done) percent_q <= div_quot;
      S_UNIT: begin
        neg_q <= diff[UsW];
        if (cfg.half_range == '0) begin
          unit_q <= '0;
        end else if (diff_abs >= cfg.half_range) begin
          unit_q <= diff[UsW] ? -UnitOne : UnitOne;
        end
      end
      S_UNIT_W: begin
        if (div_done) begin
          unit_q <= neg_q ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
        end
      end
      default: ;
    endcase
  end

  assign busy_o            = state_q != S_IDLE;
  assign done_o            = state_q == S_OUT;
  assign channel_valid_o   = chan_valid_q;
  assign width_accepted_o  = accepted_q;
  assign raw_us_o          = raw_q;
  assign clamped_us_o      = clamped_q;
  assign percent_q8_o      = percent_q;
  assign unit_q14_o        = unit_q;
  assign new_data_o        = new_q;
  assign fresh_o           = fresh_q;
  assign receiver_active_o = active_q;
  assign last_update_us_o  = last_q;

  // Checks
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result strobed while idle");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accepted item did not start work");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !channel_valid_o) |-> (raw_us_o == '0 && last_update_us_o == '0 &&
      !receiver_active_o && !width_accepted_o))
    else $error("invalid channel result not cleared");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (unit_q14_o <= UnitOne && unit_q14_o >= -UnitOne))
    else $error("unit position out of range");

endmodule

@@ tb/sv/rcpw_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rcpw_checker: result checker for the RC pulse-width capture block
// Watches the item, configuration and result channels, keeps its own copy of
// the channel store and registers, predicts one reading per accepted item and
// compares every strobed result with the oldest predicted reading.
// ----------------------------------------------------------------------------
module rcpw_checker
  import rcpw_pkg::*;
#(
  parameter int unsigned CHANNELS         = 6,
  parameter int unsigned THROTTLE_CHANNEL = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration channel
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  // item channel
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [1:0]         operation_i,
  input  logic [2:0]         channel_i,
  input  logic               level_i,
  input  logic [31:0]        time_us_i,
  // result channel
  input  logic               done_i,
  input  logic               channel_valid_i,
  input  logic               width_accepted_i,
  input  logic [11:0]        raw_us_i,
  input  logic [11:0]        clamped_us_i,
  input  logic [14:0]        percent_q8_i,
  input  logic signed [15:0] unit_q14_i,
  input  logic               new_data_i,
  input  logic               fresh_i,
  input  logic               receiver_active_i,
  input  logic [31:0]        last_update_us_i,
  // status for the testbench top
  output int unsigned        mismatches_o,
  output int unsigned        pending_o,
  output int unsigned        readings_o,
  output int unsigned        widths_taken_o,
  output int unsigned        fresh_seen_o
);

  localparam longint UNIT_ONE = 16384;
  localparam int unsigned PRINT_CAP = 40;

  // One reading as the block reports it
  typedef struct packed {
    logic               ch_ok;
    logic               accepted;
    logic [11:0]        raw;
    logic [11:0]        clamped;
    logic [14:0]        pct;
    logic signed [15:0] unit;
    logic               new_f;
    logic               fresh;
    logic               rx_active;
    logic [31:0]        last;
  } reading_t;

  // Mirror of the registers and the channel store
  cfg_t        window;
  logic [31:0] rise_us  [8];
  logic [11:0] width_us [8];
  logic        flag_new [8];
  logic [31:0] last_us  [8];

  reading_t    readings_q [$];
  reading_t    got, want;

  // Power-up width of each channel slot
  function automatic logic [11:0] boot_width(input int unsigned idx);
    case (idx)
      2, 4, 5: return 12'd1000;
      default: return 12'd1500;
    endcase
  endfunction

  function automatic void restore_defaults();
    window.valid_min  = 12'd800;
    window.valid_max  = 12'd2500;
    window.clamp_min  = 12'd1000;
    window.clamp_max  = 12'd2000;
    window.center     = 12'd1500;
    window.half_range = 12'd500;
    window.timeout    = 32'd100000;
    for (int i = 0; i < 8; i++) begin
      rise_us[i]  = '0;
      width_us[i] = boot_width(i);
      flag_new[i] = 1'b0;
      last_us[i]  = '0;
    end
  endfunction

  function automatic void apply_write(input logic [2:0] idx, input logic [31:0] val);
    case (idx)
      CFG_VALID_MIN:  window.valid_min  = val[11:0];
      CFG_VALID_MAX:  window.valid_max  = val[11:0];
      CFG_CLAMP_MIN:  window.clamp_min  = val[11:0];
      CFG_CLAMP_MAX:  window.clamp_max  = val[11:0];
      CFG_CENTER:     window.center     = val[11:0];
      CFG_HALF_RANGE: window.half_range = val[11:0];
      CFG_TIMEOUT:    window.timeout    = val;
      default: ;
    endcase
  endfunction

  // Updated at some point and no older than the timeout; wrapping age
  function automatic logic recent(input int unsigned ch, input logic [31:0] now);
    logic [31:0] age;
    if (ch >= CHANNELS) return 1'b0;
    if (last_us[ch] == '0) return 1'b0;
    age = now - last_us[ch];
    return age <= window.timeout;
  endfunction

  // Applies one item to the mirrored store and returns the reading it causes
  function automatic reading_t capture_item(input logic [1:0] op, input logic [2:0] ch,
                                            input logic lvl, input logic [31:0] now);
    reading_t        r;
    logic [31:0]     span_us;
    logic [11:0]     lim;
    longint unsigned off, span, pct_full;
    longint          a, c, hr, unit;
    r = '0;
    if (ch >= CHANNELS) return r;

    if (op == OP_EDGE) begin
      if (lvl) begin
        rise_us[ch] = now;
      end else begin
        span_us = now - rise_us[ch];
        if (span_us >= window.valid_min && span_us <= window.valid_max) begin
          width_us[ch] = span_us[11:0];
          flag_new[ch] = 1'b1;
          last_us[ch]  = now;
          r.accepted   = 1'b1;
        end
      end
    end else if (op == OP_CLEAR) begin
      flag_new[ch] = 1'b0;
    end

    r.ch_ok = 1'b1;
    r.raw   = width_us[ch];

    // raise to the low bound first, then lower to the high bound
    lim = r.raw;
    if (lim < window.clamp_min) lim = window.clamp_min;
    if (lim > window.clamp_max) lim = window.clamp_max;
    r.clamped = lim;

    if (window.clamp_max > window.clamp_min) begin
      off      = lim - window.clamp_min;
      span     = window.clamp_max - window.clamp_min;
      pct_full = off * 25600 / span;
      r.pct    = pct_full[14:0];
    end else if (window.clamp_max == window.clamp_min) begin
      r.pct = '0;
    end else begin
      r.pct = PctFull;
    end

    // signed offset about centre, truncated toward zero, held to +/-1.0
    if (window.half_range == '0) begin
      r.unit = '0;
    end else begin
      a    = r.raw;
      c    = window.center;
      hr   = window.half_range;
      unit = (a - c) * UNIT_ONE / hr;
      if (unit > UNIT_ONE) unit = UNIT_ONE;
      if (unit < -UNIT_ONE) unit = -UNIT_ONE;
      r.unit = unit[15:0];
    end

    r.new_f     = flag_new[ch];
    r.fresh     = recent(ch, now);
    r.rx_active = recent(THROTTLE_CHANNEL, now);
    r.last      = last_us[ch];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] seen,
                                 input logic [31:0] wanted);
    if (mismatches_o < PRINT_CAP)
      $display("[%0t] rcpw mismatch on reading %0d: %s got 0x%0h, expected 0x%0h",
               $time, readings_o, what, seen, wanted);
    mismatches_o++;
  endtask

  task automatic compare_reading(input reading_t seen, input reading_t wanted);
    if (seen.ch_ok !== wanted.ch_ok)
      report_mismatch("channel_valid", seen.ch_ok, wanted.ch_ok);
    if (seen.accepted !== wanted.accepted)
      report_mismatch("width_accepted", seen.accepted, wanted.accepted);
    if (seen.raw !== wanted.raw)
      report_mismatch("raw_us", seen.raw, wanted.raw);
    if (seen.clamped !== wanted.clamped)
      report_mismatch("clamped_us", seen.clamped, wanted.clamped);
    if (seen.pct !== wanted.pct)
      report_mismatch("percent_q8", seen.pct, wanted.pct);
    if (seen.unit !== wanted.unit)
      report_mismatch("unit_q14", {16'h0, seen.unit}, {16'h0, wanted.unit});
    if (seen.new_f !== wanted.new_f)
      report_mismatch("new_data", seen.new_f, wanted.new_f);
    if (seen.fresh !== wanted.fresh)
      report_mismatch("fresh", seen.fresh, wanted.fresh);
    if (seen.rx_active !== wanted.rx_active)
      report_mismatch("receiver_active", seen.rx_active, wanted.rx_active);
    if (seen.last !== wanted.last)
      report_mismatch("last_update_us", seen.last, wanted.last);
  endtask

  initial begin
    mismatches_o   = 0;
    readings_o     = 0;
    widths_taken_o = 0;
    fresh_seen_o   = 0;
  end

  // Results are checked first, then register writes, then newly accepted items
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restore_defaults();
      readings_q.delete();
      pending_o <= 0;
    end else begin
      if (done_i) begin
        got = '{channel_valid_i, width_accepted_i, raw_us_i, clamped_us_i,
                percent_q8_i, unit_q14_i, new_data_i, fresh_i, receiver_active_i,
                last_update_us_i};
        if (readings_q.size() == 0) begin
          report_mismatch("result with no item outstanding", '0, '0);
        end else begin
          want = readings_q.pop_front();
          compare_reading(got, want);
          if (want.accepted) widths_taken_o++;
          if (want.fresh) fresh_seen_o++;
        end
        readings_o++;
      end
      if (cfg_valid_i && cfg_ready_i)
        apply_write(cfg_index_i, cfg_data_i);
      if (start_i && !busy_i)
        readings_q.push_back(capture_item(operation_i, channel_i, level_i, time_us_i));
      pending_o <= readings_q.size();
    end
  end

endmodule

@@ tb/sv/tb_rc_pulse_width_capture.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rc_pulse_width_capture: testbench for the RC pulse-width capture block
// Directed edge, read and clear items at the width and time boundaries, then
// random pulse trains under several register settings, extremes included.
// Items go out in bursts with random gaps; a side checker predicts and
// compares every reading.
// ----------------------------------------------------------------------------
module tb_rc_pulse_width_capture;
  import rcpw_pkg::*;

  localparam int unsigned CHANNELS         = 6;
  localparam int unsigned THROTTLE_CHANNEL = 2;
  localparam logic [1:0]  OP_UNUSED        = 2'd3;
  localparam logic [2:0]  CFG_SPARE        = 3'd7;
  // room for ~650 items, each at its slowest and after the longest gap, many times over
  localparam int unsigned CYCLE_LIMIT      = 400_000;
  localparam int unsigned TAIL_CYCLES      = 40;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [1:0]         operation_i = '0;
  logic [2:0]         channel_i = '0;
  logic               level_i = 1'b0;
  logic [31:0]        time_us_i = '0;
  logic               done_o;
  logic               channel_valid_o;
  logic               width_accepted_o;
  logic [11:0]        raw_us_o;
  logic [11:0]        clamped_us_o;
  logic [14:0]        percent_q8_o;
  logic signed [15:0] unit_q14_o;
  logic               new_data_o;
  logic               fresh_o;
  logic               receiver_active_o;
  logic [31:0]        last_update_us_o;

  int unsigned mismatches, pending, readings, widths_taken, fresh_seen;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned settings_cnt = 0;
  int unsigned burst_left = 0;
  logic [31:0] t_us = '0;
  logic [11:0] cur_vmin = 12'd800;
  logic [11:0] cur_vmax = 12'd2500;

  rc_pulse_width_capture #(
    .CHANNELS         (CHANNELS),
    .THROTTLE_CHANNEL (THROTTLE_CHANNEL)
  ) u_top (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .start_i, .busy_o, .operation_i, .channel_i, .level_i, .time_us_i,
    .done_o, .channel_valid_o, .width_accepted_o, .raw_us_o, .clamped_us_o,
    .percent_q8_o, .unit_q14_o, .new_data_o, .fresh_o, .receiver_active_o,
    .last_update_us_o
  );

  rcpw_checker #(
    .CHANNELS         (CHANNELS),
    .THROTTLE_CHANNEL (THROTTLE_CHANNEL)
  ) u_checker (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i (cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .start_i, .busy_i (busy_o), .operation_i, .channel_i, .level_i, .time_us_i,
    .done_i            (done_o),
    .channel_valid_i   (channel_valid_o),
    .width_accepted_i  (width_accepted_o),
    .raw_us_i          (raw_us_o),
    .clamped_us_i      (clamped_us_o),
    .percent_q8_i      (percent_q8_o),
    .unit_q14_i        (unit_q14_o),
    .new_data_i        (new_data_o),
    .fresh_i           (fresh_o),
    .receiver_active_i (receiver_active_o),
    .last_update_us_i  (last_update_us_o),
    .mismatches_o      (mismatches),
    .pending_o         (pending),
    .readings_o        (readings),
    .widths_taken_o    (widths_taken),
    .fresh_seen_o      (fresh_seen)
  );

  // 50 MHz clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** rc_pulse_width_capture: FAILED **");
      $finish;
    end
  end

  // Sends one item; bursts of random length with random gaps in between
  task automatic send_item(input logic [1:0] op, input logic [2:0] ch, input logic lvl,
                           input logic [31:0] t);
    int unsigned gap;
    if (burst_left == 0) begin
      start_i <= 1'b0;
      gap = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 8) : $urandom_range(1, 45);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    start_i     <= 1'b1;
    operation_i <= op;
    channel_i   <= ch;
    level_i     <= lvl;
    time_us_i   <= t;
    do @(posedge clk_i); while (busy_o);
    items_sent++;
  endtask

  // Stop sending and wait for every outstanding reading
  task automatic wait_drain();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // 12-bit registers get junk in the unused upper bits
  task automatic write_reg12(input logic [2:0] idx, input logic [11:0] val);
    logic [31:0] junk;
    junk = $urandom();
    write_reg(idx, {junk[31:12], val});
  endtask

  task automatic program_window(input logic [11:0] vmin, input logic [11:0] vmax,
                                input logic [11:0] cmin, input logic [11:0] cmax,
                                input logic [11:0] centre, input logic [11:0] half,
                                input logic [31:0] timeout);
    wait_drain();
    write_reg12(CFG_VALID_MIN, vmin);
    write_reg12(CFG_VALID_MAX, vmax);
    write_reg12(CFG_CLAMP_MIN, cmin);
    write_reg12(CFG_CLAMP_MAX, cmax);
    write_reg12(CFG_CENTER, centre);
    write_reg12(CFG_HALF_RANGE, half);
    write_reg(CFG_TIMEOUT, timeout);
    cfg_valid_i <= 1'b0;
    cur_vmin = vmin;
    cur_vmax = vmax;
    settings_cnt++;
  endtask

  // Mostly real channels, now and then an out-of-range index
  function automatic logic [2:0] pick_channel();
    if ($urandom_range(0, 99) < 88) return 3'($urandom_range(0, CHANNELS - 1));
    return 3'($urandom_range(0, 7));
  endfunction

  // Pulse widths: inside the window, on its edges, anywhere in 12 bits, or wild
  function automatic logic [31:0] pick_width();
    int unsigned k;
    logic [31:0] lo, hi;
    k  = $urandom_range(0, 99);
    lo = cur_vmin;
    hi = cur_vmax;
    if (k < 60 && lo <= hi) return $urandom_range(lo, hi);
    if (k < 72) begin
      case ($urandom_range(0, 3))
        0:       return lo - 1;
        1:       return lo;
        2:       return hi;
        default: return hi + 1;
      endcase
    end
    if (k < 92) return $urandom_range(0, 4095);
    return $urandom();
  endfunction

  task automatic run_traffic(input int unsigned n);
    int unsigned sent0, k;
    logic [31:0] w;
    logic [2:0]  ch;
    sent0 = items_sent;
    while (items_sent - sent0 < n) begin
      k  = $urandom_range(0, 99);
      ch = pick_channel();
      if (k < 72) begin
        // rise, maybe something in between, fall, maybe a read or clear
        w = pick_width();
        send_item(OP_EDGE, ch, 1'b1, t_us);
        if ($urandom_range(0, 3) == 0)
          send_item(($urandom_range(0, 1) != 0) ? OP_READ : OP_CLEAR, pick_channel(),
                    1'($urandom_range(0, 1)), t_us + w / 2);
        t_us = t_us + w;
        send_item(OP_EDGE, ch, 1'b0, t_us);
        if ($urandom_range(0, 2) == 0)
          send_item(($urandom_range(0, 1) != 0) ? OP_READ : OP_CLEAR, ch,
                    1'($urandom_range(0, 1)), t_us);
      end else begin
        // stray item: any code, any channel, sometimes an unrelated time
        send_item(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                  1'($urandom_range(0, 1)),
                  ($urandom_range(0, 4) == 0) ? $urandom() : t_us);
      end
      // frame spacing, occasional stale gaps and jumps across the wrap
      k = $urandom_range(0, 99);
      if (k < 80)      t_us = t_us + $urandom_range(0, 25000);
      else if (k < 95) t_us = t_us + $urandom_range(0, 200000);
      else             t_us = t_us + $urandom();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed items under the reset register values
    send_item(OP_READ, 3'd0, 1'b0, 32'd0);              // reset width, never updated
    send_item(OP_READ, 3'd6, 1'b1, 32'd5);              // first invalid channel
    send_item(OP_EDGE, 3'd7, 1'b1, 32'hFFFF_FFFF);      // edge on invalid channel
    send_item(OP_EDGE, 3'd2, 1'b1, 32'd1000);
    send_item(OP_EDGE, 3'd2, 1'b0, 32'd2000);           // throttle takes 1000
    send_item(OP_READ, 3'd2, 1'b0, 32'd102000);         // age equals timeout
    send_item(OP_READ, 3'd2, 1'b0, 32'd102001);         // one past the timeout
    send_item(OP_CLEAR, 3'd2, 1'b1, 32'd102001);
    send_item(OP_UNUSED, 3'd0, 1'b1, 32'd7);            // unused code reads
    send_item(OP_EDGE, 3'd1, 1'b1, 32'hFFFF_FA00);
    send_item(OP_EDGE, 3'd1, 1'b0, 32'd0);              // wraps, stored at time zero
    send_item(OP_EDGE, 3'd1, 1'b0, 32'h0000_0100);      // same rise, later fall
    send_item(OP_EDGE, 3'd3, 1'b1, 32'd10000);
    send_item(OP_EDGE, 3'd3, 1'b0, 32'd10799);          // just short of the window
    send_item(OP_EDGE, 3'd3, 1'b0, 32'd10800);          // shortest valid width
    send_item(OP_EDGE, 3'd4, 1'b1, 32'd20000);
    send_item(OP_EDGE, 3'd4, 1'b0, 32'd22501);          // just over the window
    send_item(OP_EDGE, 3'd4, 1'b0, 32'd22500);          // longest valid width
    send_item(OP_EDGE, 3'd5, 1'b0, 32'h8000_0000);      // fall with no rise
    send_item(OP_EDGE, 3'd0, 1'b1, 32'hFFFF_FFFF);
    send_item(OP_EDGE, 3'd0, 1'b0, 32'h0000_05DB);      // centre width across the wrap
    send_item(OP_EDGE, 3'd5, 1'b1, 32'd3000);
    send_item(OP_EDGE, 3'd5, 1'b0, 32'd4250);
    send_item(OP_CLEAR, 3'd7, 1'b0, 32'h7FFF_FFFF);     // clear on invalid channel
    send_item(OP_READ, 3'd5, 1'b1, 32'hFFFF_FFFF);
    t_us = 32'd200000;

    // Wide open window, full clamp span, unit scale at its finest
    program_window(12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd1, 32'hFFFF_FFFF);
    run_traffic(75);

    // Empty window, inverted clamp bounds, zero timeout, plus the spare index
    program_window(12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095, 12'd4095, 32'd0);
    write_reg(CFG_SPARE, $urandom());
    cfg_valid_i <= 1'b0;
    run_traffic(60);

    // Zero timeout but a usable window: only items at the storing edge's own time are fresh
    program_window(12'd800, 12'd2500, 12'd2000, 12'd1000, 12'd1500, 12'd500, 32'd0);
    run_traffic(40);

    // Equal clamp bounds and zero half range
    program_window(12'd1000, 12'd2000, 12'd1500, 12'd1500, 12'd1500, 12'd0, 32'd20000);
    run_traffic(60);

    // Random settings
    repeat (4) begin
      program_window(12'($urandom_range(400, 1200)), 12'($urandom_range(1800, 3200)),
                     12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                     12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                     $urandom_range(0, 200000));
      run_traffic(70);
    end

    // Back to the usual servo settings
    program_window(12'd800, 12'd2500, 12'd1000, 12'd2000, 12'd1500, 12'd500, 32'd100000);
    run_traffic(90);

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Run covered %0d items over %0d register settings after reset:", items_sent,
             settings_cnt);
    $display("  %0d readings checked, %0d widths stored, %0d fresh, %0d mismatches",
             readings, widths_taken, fresh_seen, mismatches);
    if (mismatches == 0) begin
      $display("** rc_pulse_width_capture: PASSED **");
    end else begin
      $display("** rc_pulse_width_capture: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/rcpw_pkg.sv
hw/rtl/rcpw_cfg_regs.sv
hw/rtl/rcpw_chan_store.sv
hw/rtl/rcpw_divider.sv
hw/rtl/rc_pulse_width_capture.sv
tb/sv/rcpw_checker.sv
tb/sv/tb_rc_pulse_width_capture.sv
